// File: src/vcm_pkg.sv
// shared types, constants and helpers for the volume co-occurrence matrix
`default_nettype none
package vcm_pkg;
    localparam int MAX_EXTENT  = 32;
    localparam int GRAY_LEVELS = 256;
    localparam int NUM_OFFSETS = 13;

    localparam int CW  = $clog2(MAX_EXTENT);
    localparam int EW  = $clog2(MAX_EXTENT + 1);
    localparam int AW  = 3 * CW;
    localparam int TW  = $clog2(MAX_EXTENT * MAX_EXTENT * MAX_EXTENT + 1);
    localparam int PW  = $clog2(MAX_EXTENT * MAX_EXTENT + 1);
    localparam int GW  = $clog2(GRAY_LEVELS);
    localparam int LCW = $clog2(GRAY_LEVELS + 1);
    localparam int CAW = 2 * GW;
    localparam int NW  = $clog2(NUM_OFFSETS);

    localparam logic [19:0] COUNT_MAX = 20'hFFFFF;

    // forward offsets, one bit per offset
    localparam logic [NUM_OFFSETS-1:0] OFF_DX  = 13'h1BAD;
    localparam logic [NUM_OFFSETS-1:0] OFF_DYP = 13'h0CC6;
    localparam logic [NUM_OFFSETS-1:0] OFF_DYN = 13'h1108;
    localparam logic [NUM_OFFSETS-1:0] OFF_DZP = 13'h01F0;
    localparam logic [NUM_OFFSETS-1:0] OFF_DZN = 13'h1E00;

    typedef enum logic [1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2,
        CFG_DIR_MASK = 2'd3
    } t_cfg_idx;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] voxel_value;
        logic [7:0] row_index;
        logic [7:0] col_index;
    } t_item;

    typedef struct packed {
        logic [19:0] pair_count;
        logic [7:0]  row_level;
        logic [7:0]  col_level;
        logic [8:0]  level_count;
        logic        in_range;
    } t_result;

    typedef struct packed {
        logic [EW-1:0]          nx;
        logic [EW-1:0]          ny;
        logic [EW-1:0]          nz;
        logic [NUM_OFFSETS-1:0] mask;
        logic [PW-1:0]          area;
        logic [TW-1:0]          total;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_MARK,
        S_MARK_END,
        S_RANK,
        S_VA,
        S_VA_R,
        S_VA_K,
        S_NCHK,
        S_NB_V,
        S_NB_K,
        S_W1,
        S_R2,
        S_W2,
        S_FIN
    } t_state;

    function automatic logic [EW-1:0] eff_extent(input logic [5:0] v);
        if (v < 6'd2) return EW'(2);
        if (7'(v) > 7'(MAX_EXTENT)) return EW'(MAX_EXTENT);
        return EW'(v);
    endfunction

    function automatic logic [GW-1:0] clamp_gray(input logic [7:0] v);
        if (9'(v) >= 9'(GRAY_LEVELS)) return GW'(GRAY_LEVELS - 1);
        return GW'(v);
    endfunction

    function automatic logic [19:0] sat_inc(input logic [19:0] v);
        if (v == COUNT_MAX) return v;
        return v + 20'd1;
    endfunction
endpackage
`default_nettype wire

// File: src/volume_cooccurrence_matrix_top.sv
// top level: configuration registers and the matrix sequencer
// a non-final load answers in the next cycle; a read's result is registered in S_RD
// loads: one per cycle unless busy; reads: busy in S_RD; results are never stalled
// the last load of a volume answers after the counting pass, which ends in S_FIN
// reset and a load after a finished volume clear the count and presence memories, busy meanwhile
`default_nettype none
module volume_cooccurrence_matrix_top import vcm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_item       i_item,
    output logic             o_res_strobe,
    output t_result          o_result,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data
);
    logic [5:0]             r_size_x, r_size_y, r_size_z;
    logic [NUM_OFFSETS-1:0] r_mask;
    logic [PW-1:0]          r_area;
    logic [TW-1:0]          r_total;
    logic [1:0]             r_wait;
    logic [EW-1:0]          nx, ny, nz;
    logic                   seq_busy;
    t_cfg                   cfg;

    assign nx = eff_extent(r_size_x);
    assign ny = eff_extent(r_size_y);
    assign nz = eff_extent(r_size_z);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 6'd32;
            r_size_y <= 6'd32;
            r_size_z <= 6'd32;
            r_mask   <= NUM_OFFSETS'(1);
            r_wait   <= 2'd2;
        end else if (i_cfg_valid) begin
            r_wait <= 2'd2;
            case (t_cfg_idx'(i_cfg_index))
                CFG_SIZE_X:   r_size_x <= i_cfg_data[5:0];
                CFG_SIZE_Y:   r_size_y <= i_cfg_data[5:0];
                CFG_SIZE_Z:   r_size_z <= i_cfg_data[5:0];
                CFG_DIR_MASK: r_mask   <= i_cfg_data[NUM_OFFSETS-1:0];
                default: begin
                end
            endcase
        end else if (r_wait != 2'd0) begin
            r_wait <= r_wait - 2'd1;
        end
    end

    // voxel total in two steps
    always_ff @(posedge i_clk) begin
        r_area  <= PW'(nx * ny);
        r_total <= TW'(r_area * nz);
    end

    assign cfg = '{nx: nx, ny: ny, nz: nz, mask: r_mask, area: r_area, total: r_total};

    vcm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (start && !busy),
        .i_item      (i_item),
        .i_cfg       (cfg),
        .o_busy      (seq_busy),
        .o_res_strobe(o_res_strobe),
        .o_result    (o_result)
    );

    assign busy = seq_busy || (r_wait != 2'd0);
endmodule
`default_nettype wire

// File: src/vcm_ram.sv
// generic single write port ram with registered read
`default_nettype none
module vcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: src/vcm_seq.sv
// load, counting pass and read sequencer around the voxel, rank and count memories
`default_nettype none
module vcm_seq import vcm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output logic         o_busy,
    output logic         o_res_strobe,
    output t_result      o_result
);
    t_state r_state, n_state;

    logic [CAW-1:0]         r_clr;
    logic [AW-1:0]          r_pos;
    logic                   r_done;
    logic [LCW-1:0]         r_distinct;
    logic [AW-1:0]          r_p;
    logic [AW-1:0]          r_last;
    logic [CW-1:0]          r_cx, r_cy, r_cz;
    logic [EW-1:0]          r_nx, r_ny, r_nz;
    logic [PW-1:0]          r_plane;
    logic [NUM_OFFSETS-1:0] r_mask;
    logic [NW-1:0]          r_n;
    logic [GW-1:0]          r_rk_a, r_rk_b;
    logic [GW-1:0]          r_g;
    logic [GW-1:0]          r_g_q;
    logic [LCW-1:0]         r_r;
    logic                   r_mark_vld;
    logic                   r_rank_vld;
    logic                   r_rd_ok;
    logic                   r_out_vld;
    t_result                r_out;

    // memory ports
    logic           vox_we;
    logic [AW-1:0]  vox_waddr, vox_raddr;
    logic [GW-1:0]  vox_wdata, vox_rdata;
    logic           pr_we;
    logic [GW-1:0]  pr_waddr, pr_raddr;
    logic           pr_wdata, pr_rdata;
    logic           rk_we;
    logic [GW-1:0]  rk_waddr, rk_wdata, rk_raddr, rk_rdata;
    logic           lt_we;
    logic [GW-1:0]  lt_waddr, lt_wdata, lt_raddr_r, lt_raddr_c, lt_rdata_r, lt_rdata_c;
    logic           cc_we;
    logic [CAW-1:0] cc_waddr, cc_raddr;
    logic [19:0]    cc_wdata, cc_rdata;

    logic           acc_load, acc_read;
    logic [AW-1:0]  pos_eff;
    logic           complete;
    logic           off_ok;
    logic           last_off;
    logic           last_vox;
    logic [AW-1:0]  q_addr;
    logic           in_x, in_y, in_z;

    assign acc_load = i_accept && (r_state == S_IDLE) && (i_item.action == ACT_LOAD);
    assign acc_read = i_accept && (r_state == S_IDLE) && (i_item.action == ACT_READ);
    assign pos_eff  = r_done ? '0 : r_pos;
    assign complete = (TW'(pos_eff) + TW'(1)) >= i_cfg.total;
    assign last_off = (r_n == NW'(NUM_OFFSETS - 1));
    assign last_vox = (r_p == r_last);

    assign in_x = !OFF_DX[r_n] || ((EW'(r_cx) + EW'(1)) < r_nx);
    assign in_y = (!OFF_DYP[r_n] || ((EW'(r_cy) + EW'(1)) < r_ny))
               && (!OFF_DYN[r_n] || (r_cy != '0));
    assign in_z = (!OFF_DZP[r_n] || ((EW'(r_cz) + EW'(1)) < r_nz))
               && (!OFF_DZN[r_n] || (r_cz != '0));
    assign off_ok = r_mask[r_n] && in_x && in_y && in_z;

    assign q_addr = r_p
                  + (OFF_DX[r_n]  ? AW'(r_ny) : '0)
                  + (OFF_DYP[r_n] ? AW'(1) : '0)
                  - (OFF_DYN[r_n] ? AW'(1) : '0)
                  + (OFF_DZP[r_n] ? AW'(r_plane) : '0)
                  - (OFF_DZN[r_n] ? AW'(r_plane) : '0);

    vcm_ram #(.WIDTH(GW), .DEPTH(1 << AW)) u_vox (
        .i_clk(i_clk), .i_we(vox_we), .i_waddr(vox_waddr), .i_wdata(vox_wdata),
        .i_raddr(vox_raddr), .o_rdata(vox_rdata)
    );

    vcm_ram #(.WIDTH(1), .DEPTH(GRAY_LEVELS)) u_present (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(pr_waddr), .i_wdata(pr_wdata),
        .i_raddr(pr_raddr), .o_rdata(pr_rdata)
    );

    vcm_ram #(.WIDTH(GW), .DEPTH(GRAY_LEVELS)) u_rank (
        .i_clk(i_clk), .i_we(rk_we), .i_waddr(rk_waddr), .i_wdata(rk_wdata),
        .i_raddr(rk_raddr), .o_rdata(rk_rdata)
    );

    vcm_ram #(.WIDTH(GW), .DEPTH(GRAY_LEVELS)) u_lt_row (
        .i_clk(i_clk), .i_we(lt_we), .i_waddr(lt_waddr), .i_wdata(lt_wdata),
        .i_raddr(lt_raddr_r), .o_rdata(lt_rdata_r)
    );

    vcm_ram #(.WIDTH(GW), .DEPTH(GRAY_LEVELS)) u_lt_col (
        .i_clk(i_clk), .i_we(lt_we), .i_waddr(lt_waddr), .i_wdata(lt_wdata),
        .i_raddr(lt_raddr_c), .o_rdata(lt_rdata_c)
    );

    vcm_ram #(.WIDTH(20), .DEPTH(1 << CAW)) u_cells (
        .i_clk(i_clk), .i_we(cc_we), .i_waddr(cc_waddr), .i_wdata(cc_wdata),
        .i_raddr(cc_raddr), .o_rdata(cc_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (acc_read) begin
                    n_state = S_RD;
                end else if (acc_load) begin
                    if (complete) n_state = S_MARK;
                    else if (r_done) n_state = S_CLR;
                end
            end
            S_RD:       n_state = S_IDLE;
            S_MARK: begin
                if (last_vox) n_state = S_MARK_END;
            end
            S_MARK_END: n_state = S_RANK;
            S_RANK: begin
                if (r_g == GW'(GRAY_LEVELS - 1)) n_state = S_VA;
            end
            S_VA:       n_state = S_VA_R;
            S_VA_R:     n_state = S_VA_K;
            S_VA_K:     n_state = S_NCHK;
            S_NCHK: begin
                if (off_ok) n_state = S_NB_V;
                else if (!last_off) n_state = S_NCHK;
                else if (last_vox) n_state = S_FIN;
                else n_state = S_VA;
            end
            S_NB_V:     n_state = S_NB_K;
            S_NB_K:     n_state = S_W1;
            S_W1:       n_state = S_R2;
            S_R2:       n_state = S_W2;
            S_W2: begin
                if (!last_off) n_state = S_NCHK;
                else if (last_vox) n_state = S_FIN;
                else n_state = S_VA;
            end
            S_FIN:      n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        vox_we     = acc_load;
        vox_waddr  = pos_eff;
        vox_wdata  = clamp_gray(i_item.voxel_value);
        vox_raddr  = r_p;
        pr_we      = r_mark_vld;
        pr_waddr   = vox_rdata;
        pr_wdata   = 1'b1;
        pr_raddr   = r_g;
        rk_we      = r_rank_vld && pr_rdata;
        rk_waddr   = r_g_q;
        rk_wdata   = r_r[GW-1:0];
        rk_raddr   = vox_rdata;
        lt_we      = r_rank_vld && pr_rdata;
        lt_waddr   = r_r[GW-1:0];
        lt_wdata   = r_g_q;
        lt_raddr_r = i_item.row_index[GW-1:0];
        lt_raddr_c = i_item.col_index[GW-1:0];
        cc_we      = 1'b0;
        cc_waddr   = r_clr;
        cc_wdata   = '0;
        cc_raddr   = {i_item.row_index[GW-1:0], i_item.col_index[GW-1:0]};
        case (r_state)
            S_CLR: begin
                cc_we    = 1'b1;
                pr_we    = 1'b1;
                pr_waddr = r_clr[GW-1:0];
                pr_wdata = 1'b0;
            end
            S_NCHK: begin
                vox_raddr = q_addr;
            end
            S_NB_K: begin
                cc_raddr = {r_rk_a, rk_rdata};
            end
            S_W1: begin
                cc_we    = 1'b1;
                cc_waddr = {r_rk_a, r_rk_b};
                cc_wdata = sat_inc(cc_rdata);
            end
            S_R2: begin
                cc_raddr = {r_rk_b, r_rk_a};
            end
            S_W2: begin
                cc_we    = 1'b1;
                cc_waddr = {r_rk_b, r_rk_a};
                cc_wdata = sat_inc(cc_rdata);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_pos      <= '0;
            r_done     <= 1'b0;
            r_distinct <= '0;
            r_mark_vld <= 1'b0;
            r_rank_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_vld  <= 1'b0;
            r_mark_vld <= (r_state == S_MARK);
            r_rank_vld <= (r_state == S_RANK);
            if (r_rank_vld) begin
                if (pr_rdata) r_r <= r_r + LCW'(1);
                if (r_g_q == GW'(GRAY_LEVELS - 1)) r_distinct <= r_r + LCW'(pr_rdata);
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + CAW'(1);
                end
                S_IDLE: begin
                    if (acc_read) begin
                        r_rd_ok <= r_done
                                && (LCW'(i_item.row_index) < r_distinct)
                                && (LCW'(i_item.col_index) < r_distinct);
                    end else if (acc_load) begin
                        if (r_done) begin
                            r_distinct <= '0;
                            r_done     <= 1'b0;
                            r_clr      <= '0;
                        end
                        if (complete) begin
                            r_pos   <= '0;
                            r_p     <= '0;
                            r_last  <= AW'(i_cfg.total - TW'(1));
                            r_nx    <= i_cfg.nx;
                            r_ny    <= i_cfg.ny;
                            r_nz    <= i_cfg.nz;
                            r_plane <= i_cfg.area;
                            r_mask  <= i_cfg.mask;
                        end else begin
                            r_pos     <= pos_eff + AW'(1);
                            r_out_vld <= 1'b1;
                            r_out     <= '{pair_count: '0, row_level: '0, col_level: '0,
                                           level_count: r_done ? '0 : 9'(r_distinct),
                                           in_range: 1'b0};
                        end
                    end
                end
                S_RD: begin
                    r_out_vld <= 1'b1;
                    if (r_rd_ok) begin
                        r_out <= '{pair_count: cc_rdata, row_level: 8'(lt_rdata_r),
                                   col_level: 8'(lt_rdata_c), level_count: 9'(r_distinct),
                                   in_range: 1'b1};
                    end else begin
                        r_out <= '{pair_count: '0, row_level: '0, col_level: '0,
                                   level_count: 9'(r_distinct), in_range: 1'b0};
                    end
                end
                S_MARK: begin
                    r_p <= r_p + AW'(1);
                end
                S_MARK_END: begin
                    r_g <= '0;
                    r_r <= '0;
                end
                S_RANK: begin
                    r_g   <= r_g + GW'(1);
                    r_g_q <= r_g;
                    if (r_g == GW'(GRAY_LEVELS - 1)) begin
                        r_p  <= '0;
                        r_cx <= '0;
                        r_cy <= '0;
                        r_cz <= '0;
                    end
                end
                S_VA_K: begin
                    r_rk_a <= rk_rdata;
                    r_n    <= '0;
                end
                S_NB_K: begin
                    r_rk_b <= rk_rdata;
                end
                S_FIN: begin
                    r_done    <= 1'b1;
                    r_out_vld <= 1'b1;
                    r_out     <= '{pair_count: '0, row_level: '0, col_level: '0,
                                   level_count: 9'(r_distinct), in_range: 1'b0};
                end
                default: begin
                end
            endcase
            // step to the next offset or the next voxel
            if ((r_state == S_NCHK && !off_ok) || r_state == S_W2) begin
                if (!last_off) begin
                    r_n <= r_n + NW'(1);
                end else if (!last_vox) begin
                    r_p <= r_p + AW'(1);
                    if (EW'(r_cy) == r_ny - EW'(1)) begin
                        r_cy <= '0;
                        if (EW'(r_cx) == r_nx - EW'(1)) begin
                            r_cx <= '0;
                            r_cz <= r_cz + CW'(1);
                        end else begin
                            r_cx <= r_cx + CW'(1);
                        end
                    end else begin
                        r_cy <= r_cy + CW'(1);
                    end
                end
            end
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_res_strobe = r_out_vld;
    assign o_result     = r_out;
endmodule
`default_nettype wire

// File: test/tb_volume_cooccurrence_matrix_top.sv
// testbench for the volume co-occurrence matrix: predicted results checked in order
`timescale 1ns / 100ps
`default_nettype none

module tb_volume_cooccurrence_matrix_top;
    import vcm_pkg::*;

    class cooc_scoreboard;
        bit [5:0]    sx, sy, sz;
        bit [12:0]   dmask;
        bit [7:0]    vox[32768];
        bit          present[256];
        bit [7:0]    ltab[256];
        int unsigned rank[256];
        bit [19:0]   cells[65536];
        int unsigned pos, nlev;
        bit          done;
        t_result     expq[$];
        int          errors;
        int          odx[13] = '{1, 0, 1, 1, 0, 1, 0, 1, 1, 1, 0, 1, 1};
        int          ody[13] = '{0, 1, 1, -1, 0, 0, 1, 1, -1, 0, 1, 1, -1};
        int          odz[13] = '{0, 0, 0, 0, 1, 1, 1, 1, 1, -1, -1, -1, -1};

        function new();
            sx = 32; sy = 32; sz = 32; dmask = 1;
            pos = 0; nlev = 0; done = 0; errors = 0;
            foreach (present[g]) present[g] = 0;
            foreach (cells[i]) cells[i] = '0;
        endfunction

        function int extent(bit [5:0] v);
            if (v < 2) return 2;
            if (v > MAX_EXTENT) return MAX_EXTENT;
            return int'(v);
        endfunction

        function void write_reg(t_cfg_idx idx, bit [12:0] d);
            case (idx)
                CFG_SIZE_X:   sx = d[5:0];
                CFG_SIZE_Y:   sy = d[5:0];
                CFG_SIZE_Z:   sz = d[5:0];
                CFG_DIR_MASK: dmask = d;
            endcase
        endfunction

        function void bump(int unsigned a, int unsigned b);
            int unsigned i;
            i = a * 256 + b;
            if (cells[i] != COUNT_MAX) cells[i] = cells[i] + 1;
        endfunction

        function void tally(int nx, int ny, int nz);
            int unsigned r, a, b;
            int qx, qy, qz;
            r = 0;
            for (int p = 0; p < nx * ny * nz; p++) present[vox[p]] = 1;
            for (int g = 0; g < 256; g++) begin
                if (present[g]) begin
                    ltab[r] = g[7:0];
                    rank[g] = r;
                    r++;
                end
            end
            nlev = r;
            for (int z = 0; z < nz; z++)
                for (int x = 0; x < nx; x++)
                    for (int y = 0; y < ny; y++) begin
                        a = rank[vox[y + x * ny + z * ny * nx]];
                        for (int n = 0; n < 13; n++) begin
                            qx = x + odx[n]; qy = y + ody[n]; qz = z + odz[n];
                            if (!dmask[n]) continue;
                            if (qx < 0 || qx >= nx || qy < 0 || qy >= ny || qz < 0 || qz >= nz)
                                continue;
                            b = rank[vox[qy + qx * ny + qz * ny * nx]];
                            bump(a, b);
                            bump(b, a);
                        end
                    end
            done = 1;
        endfunction

        function void note(t_item it);
            t_result e;
            int nx, ny, nz;
            e = '0;
            if (it.action == ACT_LOAD) begin
                nx = extent(sx); ny = extent(sy); nz = extent(sz);
                if (done) begin
                    foreach (present[g]) present[g] = 0;
                    foreach (cells[i]) cells[i] = '0;
                    nlev = 0; done = 0; pos = 0;
                end
                vox[pos % 32768] = it.voxel_value;
                if (pos + 1 >= nx * ny * nz) begin
                    tally(nx, ny, nz);
                    pos = 0;
                end else begin
                    pos++;
                end
            end else if (done && it.row_index < nlev && it.col_index < nlev) begin
                e.pair_count = cells[it.row_index * 256 + it.col_index];
                e.row_level  = ltab[it.row_index];
                e.col_level  = ltab[it.col_index];
                e.in_range   = 1;
            end
            e.level_count = nlev[8:0];
            expq.push_back(e);
        endfunction

        function void check(t_result r);
            t_result e;
            if (expq.size() == 0) begin
                $error("result with no expectation: %p", r);
                errors++;
                return;
            end
            e = expq.pop_front();
            if (r.pair_count !== e.pair_count) begin
                $error("pair_count expected %0d actual %0d", e.pair_count, r.pair_count);
                errors++;
            end
            if (r.row_level !== e.row_level) begin
                $error("row_level expected %0d actual %0d", e.row_level, r.row_level);
                errors++;
            end
            if (r.col_level !== e.col_level) begin
                $error("col_level expected %0d actual %0d", e.col_level, r.col_level);
                errors++;
            end
            if (r.level_count !== e.level_count) begin
                $error("level_count expected %0d actual %0d", e.level_count, r.level_count);
                errors++;
            end
            if (r.in_range !== e.in_range) begin
                $error("in_range expected %0d actual %0d", e.in_range, r.in_range);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    t_item       i_item = '0;
    logic        o_res_strobe;
    t_result     o_result;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;

    cooc_scoreboard sb = new();
    bit burst;
    int idle_cycles = 0;
    localparam int IDLE_LIMIT = 400000;

    volume_cooccurrence_matrix_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_res_strobe(o_res_strobe), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) sb.check(o_result);
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_volume_cooccurrence_matrix_top: FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(t_item it);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            @(negedge i_clk) start = 0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_item = it;
        start = 1;
        do @(posedge i_clk); while (busy);
        sb.note(it);
    endtask

    task automatic load_voxel(bit [7:0] v);
        t_item it;
        it = t_item'($urandom());
        it.action = ACT_LOAD;
        it.voxel_value = v;
        send_item(it);
    endtask

    task automatic read_cell(bit [7:0] r, bit [7:0] c);
        t_item it;
        it = t_item'($urandom());
        it.action = ACT_READ;
        it.row_index = r;
        it.col_index = c;
        send_item(it);
    endtask

    // let every outstanding transfer finish before touching registers
    task automatic settle();
        @(negedge i_clk) start = 0;
        while (sb.expq.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, bit [12:0] d);
        int gap;
        gap = $urandom_range(0, 19);
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        @(negedge i_clk) i_cfg_valid = 0;
    endtask

    task automatic set_volume(bit [12:0] x, bit [12:0] y, bit [12:0] z, bit [12:0] m);
        settle();
        cfg_write(CFG_SIZE_X, x);
        cfg_write(CFG_SIZE_Y, y);
        cfg_write(CFG_SIZE_Z, z);
        cfg_write(CFG_DIR_MASK, m);
    endtask

    function automatic bit [12:0] pick_extent();
        case ($urandom_range(0, 9))
            0:       return 13'($urandom_range(0, 1));
            1:       return 13'($urandom_range(32, 63)) | 13'($urandom_range(0, 1) << 12);
            default: return 13'($urandom_range(2, 4));
        endcase
    endfunction

    initial begin
        int nvox, nreads, big;
        bit [7:0] pal[4];
        bit use_pal;
        bit [7:0] v;
        bit [12:0] ex, ey, ez;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1;

        // reads before any volume exists
        burst = 0;
        read_cell(8'd0, 8'd0);
        read_cell(8'd255, 8'd255);

        // smallest volume, extents clamped up, all offsets
        set_volume(13'd0, 13'd1, 13'd2, 13'h1FFF);
        load_voxel(8'd0);
        read_cell(8'd0, 8'd0);
        load_voxel(8'd255);
        load_voxel(8'd0);
        load_voxel(8'd128);
        load_voxel(8'd255);
        load_voxel(8'd1);
        load_voxel(8'd0);
        load_voxel(8'd254);
        read_cell(8'd0, 8'd0);
        read_cell(8'd0, 8'd4);
        read_cell(8'd4, 8'd0);
        read_cell(8'd2, 8'd3);
        read_cell(8'd5, 8'd0);
        read_cell(8'd255, 8'd1);

        // extents shrink during a load
        set_volume(13'd2, 13'd2, 13'd4, 13'd0);
        for (int i = 0; i < 9; i++) load_voxel(8'($urandom_range(0, 2)));
        settle();
        cfg_write(CFG_SIZE_Z, 13'd2);
        cfg_write(CFG_DIR_MASK, 13'h1);
        load_voxel(8'd7);
        read_cell(8'd0, 8'd1);
        read_cell(8'd1, 8'd1);

        for (int vol = 0; vol < 9; vol++) begin
            big = (vol == 4) ? 1 : 0;
            if (big) begin
                set_volume(13'd63, 13'd2, 13'd2, 13'h1FFF);
            end else begin
                // keep each volume at 128 voxels or fewer
                do begin
                    ex = pick_extent();
                    ey = pick_extent();
                    ez = pick_extent();
                end while (sb.extent(ex[5:0]) * sb.extent(ey[5:0]) * sb.extent(ez[5:0])
                           > 128);
                set_volume(ex, ey, ez,
                           (vol == 2) ? 13'h0 : (vol == 6) ? 13'h1FFF : 13'($urandom()));
            end
            nvox = sb.extent(sb.sx) * sb.extent(sb.sy) * sb.extent(sb.sz);
            use_pal = $urandom_range(0, 1);
            foreach (pal[k]) pal[k] = 8'($urandom());
            burst = $urandom_range(0, 2) == 0;
            for (int i = 0; i < nvox; i++) begin
                if ($urandom_range(0, 7) == 0)
                    read_cell(8'($urandom()), 8'($urandom()));
                v = use_pal ? pal[$urandom_range(0, 3)] : 8'($urandom());
                load_voxel(v);
            end
            nreads = 160;
            for (int i = 0; i < nreads; i++) begin
                if (i % 40 == 0) burst = $urandom_range(0, 2) == 0;
                if ($urandom_range(0, 4) == 0 || sb.nlev == 0)
                    read_cell(8'($urandom()), 8'($urandom()));
                else
                    read_cell(8'($urandom_range(0, sb.nlev - 1)),
                              8'($urandom_range(0, sb.nlev - 1)));
            end
        end

        @(negedge i_clk) start = 0;
        while (sb.expq.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expq.size() == 0) begin
            $display("tb_volume_cooccurrence_matrix_top: PASS");
        end else begin
            $display("tb_volume_cooccurrence_matrix_top: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
